// ===== sv/h264_rtp_fua_packetizer_macros.svh =====
// Assertion macros shared by the packetizer checks.
`ifndef H264_RTP_FUA_PACKETIZER_MACROS_SVH
`define H264_RTP_FUA_PACKETIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FUA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packetizer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FUA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packetizer check failed");

`endif

// ===== sv/h264fua_pkg.sv =====
// Shared types and constants of the H.264 FU-A packetizer.
package h264fua_pkg;

	localparam int NAL_BITS        = 20;
	localparam int PLEN_BITS       = 11;
	localparam int TS_INC_BITS     = 17;
	localparam int CFG_IDX_BITS    = 4;
	localparam int CFG_DATA_BITS   = 17;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_PTR_BITS  = 2;

	localparam logic [PLEN_BITS-1:0]   LIMIT_MIN       = 11'd2;
	localparam logic [PLEN_BITS-1:0]   LIMIT_MAX       = 11'd2045;
	localparam logic [PLEN_BITS-1:0]   MAX_PAYLOAD_RST = 11'd1400;
	localparam logic [TS_INC_BITS-1:0] TS_INC_RST      = 17'd3000;

	localparam logic [7:0] TYPE_MASK = 8'h1F;
	localparam logic [7:0] NRI_MASK  = 8'h60;
	localparam logic [7:0] FU_A_TYPE = 8'd28;
	localparam logic [7:0] FU_START  = 8'h80;
	localparam logic [7:0] FU_END    = 8'h40;
	localparam logic [7:0] TYPE_SPS  = 8'd7;
	localparam logic [7:0] TYPE_PPS  = 8'd8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MAX_PAYLOAD = 4'd0,
		REG_TS_INC      = 4'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_HDR,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [7:0]          nal_byte;
		logic [NAL_BITS-1:0] nal_length;
		logic                first_of_nal;
	} nal_in_t;

	typedef struct packed {
		logic [7:0]           out_byte;
		logic                 packet_first;
		logic                 packet_last;
		logic [PLEN_BITS-1:0] packet_length;
		logic [15:0]          seq_number;
		logic [31:0]          rtp_timestamp;
		logic                 is_fragment;
		logic                 last_of_run;
	} pkt_out_t;

	// One classified input byte: an optional FU indicator/header pair and a data byte.
	typedef struct packed {
		logic                 with_fu;
		logic [7:0]           fu_ind;
		logic [7:0]           fu_hdr;
		logic [7:0]           data;
		logic                 data_first;
		logic                 data_last;
		logic [PLEN_BITS-1:0] plen;
		logic [15:0]          seq;
		logic [31:0]          ts;
		logic                 frag;
	} job_t;

endpackage

// ===== sv/h264_rtp_fua_packetizer.sv =====
// Top level of the H.264 RTP packetizer: single NAL unit packets and FU-A fragments.
//
//   channel | direction | payload                          | transaction when
//   --------+-----------+----------------------------------+---------------------------
//   nal     | in        | nal_byte, nal_length, first      | nal_valid & nal_ready
//   pkt     | out       | byte, packet flags, length, seq, | pkt_valid & pkt_ready
//           |           | timestamp, fragment, run end     |
//   cfg     | in        | cfg_index, cfg_data              | cfg_valid & cfg_ready
//
// One NAL byte is taken per cycle while the job queue has room. A byte gives one
// output byte, three at a fragment start (indicator, FU header, data), or none for
// the header byte of a fragmented unit. Output bytes leave one per cycle while
// pkt_ready allows; the back end limits the rate and the four-entry queue absorbs
// the extra header cycles. Bytes pass through a queue slot and the output register.
// Reset clears the unit state, counters, queue pointers and output valid flag, and
// loads the register defaults. The configuration port is always ready.
module h264_rtp_fua_packetizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  nal_valid,
	output logic                                  nal_ready,
	input  h264fua_pkg::nal_in_t                  nal,
	output logic                                  pkt_valid,
	input  logic                                  pkt_ready,
	output h264fua_pkg::pkt_out_t                 pkt,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [h264fua_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [h264fua_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import h264fua_pkg::*;

	// Front to queue: classified jobs.
	job_t push_job;
	logic push;
	logic full;

	// Queue to back.
	job_t head;
	logic empty;
	logic pop;

	// Classify bytes, keep sequence and timestamp counters, hold config.
	h264fua_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal_valid (nal_valid),
		.nal_ready (nal_ready),
		.nal       (nal),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.full      (full),
		.push      (push),
		.job       (push_job)
	);

	// Decouple the byte input from the output stalls.
	h264fua_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// Expand jobs into output transactions through the output register.
	h264fua_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

endmodule

// ===== sv/h264fua_front.sv =====
// Front end: accepts NAL bytes, tracks unit state and builds jobs.
module h264fua_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   nal_valid,
	output logic                                   nal_ready,
	input  h264fua_pkg::nal_in_t                   nal,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [h264fua_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [h264fua_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                   full,
	output logic                                   push,
	output h264fua_pkg::job_t                      job
);
	import h264fua_pkg::*;

	logic [PLEN_BITS-1:0]   max_payload_q;
	logic [TS_INC_BITS-1:0] ts_inc_q;
	logic [7:0]             hdr_q, hdr_d;
	logic [NAL_BITS-1:0]    bytes_left_q, bytes_left_d;
	logic [PLEN_BITS-1:0]   fill_q, fill_d;
	logic                   frag_q, frag_d;
	logic                   ffp_q, ffp_d;
	logic [15:0]            seq_q, seq_d;
	logic [31:0]            ts_q, ts_d;
	logic [PLEN_BITS-1:0]   psize_q, psize_d;

	logic                   acc;
	logic [PLEN_BITS-1:0]   limit;
	logic [NAL_BITS-1:0]    limit_ext;
	logic [NAL_BITS-1:0]    len_eff;
	logic [NAL_BITS-1:0]    len_m1;
	logic                   fits;
	logic [NAL_BITS-1:0]    bl_dec;
	logic [PLEN_BITS-1:0]   chunk_raw;
	logic [PLEN_BITS-1:0]   chunk;
	logic                   chunk_whole;
	logic [7:0]             fh;
	logic [PLEN_BITS-1:0]   psize_new;
	logic [PLEN_BITS-1:0]   psize_eff;
	logic [PLEN_BITS:0]     fill_inc;
	logic                   frag_last;
	logic [31:0]            ts_adv;
	logic                   keep_ts_new;
	logic                   keep_ts_cur;

	assign nal_ready = !full;
	assign cfg_ready = 1'b1;
	assign acc       = nal_valid && nal_ready;

	always_comb begin
		if (max_payload_q < LIMIT_MIN) begin
			limit = LIMIT_MIN;
		end else if (max_payload_q > LIMIT_MAX) begin
			limit = LIMIT_MAX;
		end else begin
			limit = max_payload_q;
		end
	end

	assign limit_ext = {{(NAL_BITS-PLEN_BITS){1'b0}}, limit};
	assign len_eff   = (nal.nal_length == '0) ? NAL_BITS'(1) : nal.nal_length;
	assign len_m1    = len_eff - NAL_BITS'(1);
	assign fits      = len_eff <= limit_ext;
	assign bl_dec    = bytes_left_q - NAL_BITS'(1);

	// Fragment size, shortened by one when the whole rest would fit the first fragment.
	assign chunk_raw   = (bytes_left_q < limit_ext) ? bytes_left_q[PLEN_BITS-1:0] : limit;
	assign chunk_whole = ffp_q
		&& ({{(NAL_BITS-PLEN_BITS){1'b0}}, chunk_raw} == bytes_left_q)
		&& (chunk_raw > PLEN_BITS'(1));
	assign chunk       = chunk_whole ? chunk_raw - PLEN_BITS'(1) : chunk_raw;
	assign psize_new   = chunk + PLEN_BITS'(2);
	assign psize_eff   = (fill_q == '0) ? psize_new : psize_q;

	always_comb begin
		fh = hdr_q & TYPE_MASK;
		if (ffp_q) begin
			fh = fh | FU_START;
		end else if ({{(NAL_BITS-PLEN_BITS){1'b0}}, chunk} == bytes_left_q) begin
			fh = fh | FU_END;
		end
	end

	assign fill_inc  = {1'b0, fill_q} + (PLEN_BITS+1)'(1);
	assign frag_last = (fill_inc + (PLEN_BITS+1)'(2) >= {1'b0, psize_eff}) || (bl_dec == '0);
	assign ts_adv    = ts_q + {{(32-TS_INC_BITS){1'b0}}, ts_inc_q};

	assign keep_ts_new = ((nal.nal_byte & TYPE_MASK) != TYPE_SPS)
		&& ((nal.nal_byte & TYPE_MASK) != TYPE_PPS);
	assign keep_ts_cur = ((hdr_q & TYPE_MASK) != TYPE_SPS)
		&& ((hdr_q & TYPE_MASK) != TYPE_PPS);

	always_comb begin
		hdr_d        = hdr_q;
		bytes_left_d = bytes_left_q;
		fill_d       = fill_q;
		frag_d       = frag_q;
		ffp_d        = ffp_q;
		seq_d        = seq_q;
		ts_d         = ts_q;
		psize_d      = psize_q;
		push         = 1'b0;

		job.with_fu    = 1'b0;
		job.fu_ind     = (hdr_q & NRI_MASK) | FU_A_TYPE;
		job.fu_hdr     = fh;
		job.data       = nal.nal_byte;
		job.data_first = 1'b0;
		job.data_last  = 1'b0;
		job.plen       = psize_q;
		job.seq        = seq_q;
		job.ts         = ts_q;
		job.frag       = 1'b0;

		if (acc) begin
			if (nal.first_of_nal) begin
				hdr_d        = nal.nal_byte;
				fill_d       = '0;
				ffp_d        = 1'b0;
				bytes_left_d = len_m1;
				if (fits) begin
					frag_d         = 1'b0;
					psize_d        = len_eff[PLEN_BITS-1:0];
					push           = 1'b1;
					job.data_first = 1'b1;
					job.data_last  = (len_m1 == '0);
					job.plen       = len_eff[PLEN_BITS-1:0];
					if (len_m1 == '0) begin
						seq_d = seq_q + 16'd1;
						if (keep_ts_new) begin
							ts_d = ts_adv;
						end
					end
				end else begin
					// Header byte of a fragmented unit: hold it, emit nothing.
					frag_d = 1'b1;
					ffp_d  = 1'b1;
				end
			end else if (bytes_left_q != '0) begin
				bytes_left_d = bl_dec;
				push         = 1'b1;
				if (!frag_q) begin
					job.data_last = (bl_dec == '0);
					if (bl_dec == '0) begin
						seq_d = seq_q + 16'd1;
						if (keep_ts_cur) begin
							ts_d = ts_adv;
						end
					end
				end else begin
					job.with_fu   = (fill_q == '0);
					job.frag      = 1'b1;
					job.plen      = psize_eff;
					job.data_last = frag_last;
					if (fill_q == '0) begin
						psize_d = psize_new;
						ffp_d   = 1'b0;
					end
					fill_d = fill_inc[PLEN_BITS-1:0];
					if (frag_last) begin
						seq_d  = seq_q + 16'd1;
						fill_d = '0;
					end
					if (bl_dec == '0) begin
						frag_d = 1'b0;
						if (keep_ts_cur) begin
							ts_d = ts_adv;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q        <= '0;
			bytes_left_q <= '0;
			fill_q       <= '0;
			frag_q       <= 1'b0;
			ffp_q        <= 1'b0;
			seq_q        <= '0;
			ts_q         <= '0;
			psize_q      <= '0;
		end else begin
			hdr_q        <= hdr_d;
			bytes_left_q <= bytes_left_d;
			fill_q       <= fill_d;
			frag_q       <= frag_d;
			ffp_q        <= ffp_d;
			seq_q        <= seq_d;
			ts_q         <= ts_d;
			psize_q      <= psize_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			ts_inc_q      <= TS_INC_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data[PLEN_BITS-1:0];
				REG_TS_INC:      ts_inc_q      <= cfg_data[TS_INC_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/h264fua_queue.sv =====
// Short job queue between front and back.
module h264fua_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  h264fua_pkg::job_t push_job,
	output logic              full,
	input  logic              pop,
	output h264fua_pkg::job_t head,
	output logic              empty
);
	import h264fua_pkg::*;

	job_t                    slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full  = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_PTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/h264fua_back.sv =====
// Back end: expands each job into one or three output bytes.
module h264fua_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  h264fua_pkg::job_t     head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  pkt_valid,
	input  logic                  pkt_ready,
	output h264fua_pkg::pkt_out_t pkt
);
	import h264fua_pkg::*;

	phase_t   phase_q, phase_d;
	pkt_out_t pkt_q, item;
	logic     pkt_valid_q;
	logic     load;

	assign load      = !empty && (!pkt_valid_q || pkt_ready);
	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

	always_comb begin
		phase_d            = phase_q;
		pop                = 1'b0;
		item.out_byte      = head.data;
		item.packet_first  = head.data_first;
		item.packet_last   = head.data_last;
		item.packet_length = head.plen;
		item.seq_number    = head.seq;
		item.rtp_timestamp = head.ts;
		item.is_fragment   = head.frag;
		item.last_of_run   = 1'b1;
		case (phase_q)
			PH_START: begin
				if (head.with_fu) begin
					item.out_byte     = head.fu_ind;
					item.packet_first = 1'b1;
					item.packet_last  = 1'b0;
					item.last_of_run  = 1'b0;
					if (load) begin
						phase_d = PH_HDR;
					end
				end else begin
					pop = load;
				end
			end
			PH_HDR: begin
				item.out_byte     = head.fu_hdr;
				item.packet_first = 1'b0;
				item.packet_last  = 1'b0;
				item.last_of_run  = 1'b0;
				if (load) begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				pop = load;
				if (load) begin
					phase_d = PH_START;
				end
			end
			default: begin
				phase_d = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			pkt_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				pkt_valid_q <= 1'b1;
			end else if (pkt_ready) begin
				pkt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q <= item;
		end
	end

endmodule

// ===== sv/h264fua_checker.sv =====
// Port-level checks of the packetizer, bound to the top level.
`include "h264_rtp_fua_packetizer_macros.svh"

module h264fua_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pkt_valid,
	input logic                  pkt_ready,
	input h264fua_pkg::pkt_out_t pkt
);
	import h264fua_pkg::*;

	// A stalled output transaction holds.
	`FUA_ASSERT_NEXT(a_pkt_hold, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt))

	// The data byte that closes a packet is always the last of its run.
	`FUA_ASSERT_NOW(a_last_ends_run, pkt_valid && pkt.packet_last, pkt.last_of_run)

	// An FU indicator never ends its run or its packet; its FU header follows in the same run.
	`FUA_ASSERT_NOW(a_ind_not_final, pkt_valid && pkt.packet_first && pkt.is_fragment,
		!pkt.last_of_run && !pkt.packet_last)

	// Every packet has a nonzero length.
	`FUA_ASSERT_NOW(a_len_nonzero, pkt_valid, pkt.packet_length != '0)

endmodule

bind h264_rtp_fua_packetizer h264fua_checker u_checker (.*);
